// ===== design/rle_sprite_blitter_top_macros.svh =====
// assertion helpers for the sprite blitter checker
`ifndef RLE_SPRITE_BLITTER_TOP_MACROS_SVH
`define RLE_SPRITE_BLITTER_TOP_MACROS_SVH

// same-cycle implication, off while in reset
`define RSB_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rsb check failed");

// next-cycle implication, off while in reset
`define RSB_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rsb check failed");

// next-cycle implication that also holds through reset
`define RSB_AST_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("rsb check failed");

`endif

// ===== design/rsb_pkg.sv =====
`timescale 1ns / 1ps

package rsb_pkg;

    localparam int DEF_ROW_STRIDE = 640;
    localparam int DEF_ADDR_BITS  = 20;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int LEN_W    = 12;
    localparam int ORIGIN_W = 17;
    localparam int COORD_W  = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ROW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_COL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HDR_HI,
        PH_ROW_LO,
        PH_ROW_HI,
        PH_COL_LO,
        PH_COL_HI,
        PH_WID_LO,
        PH_WID_HI,
        PH_HGT_LO,
        PH_HGT_HI,
        PH_RAW,
        PH_CTRL_LO,
        PH_CTRL_HI,
        PH_LIT
    } t_phase;

    typedef struct packed {
        logic valid;
        logic write_en;
        logic done;
    } t_res_flags;

endpackage

// ===== design/rsb_parser.sv =====
`timescale 1ns / 1ps

module rsb_parser
    import rsb_pkg::*;
#(
    parameter int ROW_STRIDE = DEF_ROW_STRIDE,
    parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [BYTE_W-1:0]    i_record_byte,
    input  logic                 i_record_start,
    input  logic [COORD_W-1:0]   i_base_row,
    input  logic [COORD_W-1:0]   i_base_col,
    input  logic                 i_transparent,
    output t_res_flags           o_flags,
    output logic [ADDR_BITS-1:0] o_address,
    output logic [BYTE_W-1:0]    o_pixel,
    output logic [LEN_W-1:0]     o_length
);

    localparam int STRIDE_W = $clog2(ROW_STRIDE + 1);
    localparam int PROD_W   = ORIGIN_W + STRIDE_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int WIDE_W   = (SUM_W > ADDR_BITS) ? SUM_W : ADDR_BITS;

    t_phase                r_phase, n_phase;
    logic [BYTE_W-1:0]     r_low, n_low;
    logic [1:0]            r_flags, n_flags;
    logic [ORIGIN_W-1:0]   r_row_origin, n_row_origin;
    logic [ORIGIN_W-1:0]   r_col_origin, n_col_origin;
    logic [WORD_W-1:0]     r_width, n_width;
    logic [WORD_W-1:0]     r_rows_left, n_rows_left;
    logic [WORD_W-1:0]     r_cols_left, n_cols_left;
    logic [LEN_W-1:0]      r_run_left, n_run_left;
    logic                  r_run_ends_row, n_run_ends_row;
    logic [ADDR_BITS-1:0]  r_row_addr, n_row_addr;
    logic [ADDR_BITS-1:0]  r_cur, n_cur;

    logic [WORD_W-1:0]     w_word;
    logic [LEN_W-1:0]      w_count;
    logic                  w_ends;
    logic                  w_fill_bit;
    logic                  w_row_end;
    logic                  w_last_row;
    logic [PROD_W-1:0]     w_prod;
    logic [WIDE_W-1:0]     w_origin_sum;
    logic [ADDR_BITS-1:0]  w_origin_addr;
    logic [ADDR_BITS-1:0]  w_next_row;
    logic                  w_write;
    logic                  w_done;
    logic [BYTE_W-1:0]     w_pix;
    logic [LEN_W-1:0]      w_len;

    assign w_word     = {i_record_byte, r_low};
    assign w_count    = w_word[LEN_W-1:0];
    assign w_ends     = w_word[14];
    assign w_fill_bit = w_word[15];
    assign w_last_row = (r_rows_left == WORD_W'(1));

    // start address of the first row: origin row times stride plus origin column
    assign w_prod        = PROD_W'(r_row_origin) * PROD_W'(ROW_STRIDE);
    assign w_origin_sum  = WIDE_W'(w_prod) + WIDE_W'(r_col_origin);
    assign w_origin_addr = w_origin_sum[ADDR_BITS-1:0];
    assign w_next_row    = r_row_addr + ADDR_BITS'(ROW_STRIDE);

    // this beat closes the current row
    assign w_row_end =
        ((r_phase == PH_RAW) && (r_cols_left == WORD_W'(1))) ||
        ((r_phase == PH_CTRL_HI) && w_ends && (w_fill_bit || (w_count == '0))) ||
        ((r_phase == PH_LIT) && (r_run_left == LEN_W'(1)) && r_run_ends_row);

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_low          = r_low;
        n_flags        = r_flags;
        n_row_origin   = r_row_origin;
        n_col_origin   = r_col_origin;
        n_width        = r_width;
        n_rows_left    = r_rows_left;
        n_cols_left    = r_cols_left;
        n_run_left     = r_run_left;
        n_run_ends_row = r_run_ends_row;
        n_row_addr     = r_row_addr;
        n_cur          = r_cur;
        if (i_step) begin
            if (i_record_start) begin
                n_flags = i_record_byte[1:0];
                n_phase = PH_HDR_HI;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    PH_HDR_HI: begin
                        n_row_origin = ORIGIN_W'(i_base_row);
                        n_col_origin = ORIGIN_W'(i_base_col);
                        n_phase      = r_flags[1] ? PH_ROW_LO : PH_WID_LO;
                    end
                    PH_ROW_LO: begin
                        n_low   = i_record_byte;
                        n_phase = PH_ROW_HI;
                    end
                    PH_COL_LO: begin
                        n_low   = i_record_byte;
                        n_phase = PH_COL_HI;
                    end
                    PH_WID_LO: begin
                        n_low   = i_record_byte;
                        n_phase = PH_WID_HI;
                    end
                    PH_HGT_LO: begin
                        n_low   = i_record_byte;
                        n_phase = PH_HGT_HI;
                    end
                    PH_CTRL_LO: begin
                        n_low   = i_record_byte;
                        n_phase = PH_CTRL_HI;
                    end
                    PH_ROW_HI: begin
                        n_row_origin = r_row_origin + ORIGIN_W'(w_word);
                        n_phase      = PH_COL_LO;
                    end
                    PH_COL_HI: begin
                        n_col_origin = r_col_origin + ORIGIN_W'(w_word);
                        n_phase      = PH_WID_LO;
                    end
                    PH_WID_HI: begin
                        n_width = w_word;
                        n_phase = PH_HGT_LO;
                    end
                    PH_HGT_HI: begin
                        n_rows_left = w_word;
                        if ((r_width == '0) || (w_word == '0)) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_row_addr  = w_origin_addr;
                            n_cur       = w_origin_addr;
                            n_cols_left = r_width;
                            n_phase     = r_flags[0] ? PH_CTRL_LO : PH_RAW;
                        end
                    end
                    PH_RAW: begin
                        n_cur       = r_cur + ADDR_BITS'(1);
                        n_cols_left = r_cols_left - WORD_W'(1);
                    end
                    PH_CTRL_HI: begin
                        if (!w_fill_bit && (w_count != '0)) begin
                            n_run_left     = w_count;
                            n_run_ends_row = w_ends;
                            n_phase        = PH_LIT;
                        end else begin
                            n_cur   = r_cur + ADDR_BITS'(w_count);
                            n_phase = PH_CTRL_LO;
                        end
                    end
                    PH_LIT: begin
                        n_cur      = r_cur + ADDR_BITS'(1);
                        n_run_left = r_run_left - LEN_W'(1);
                        if (r_run_left == LEN_W'(1)) begin
                            n_phase = PH_CTRL_LO;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
                if (w_row_end) begin
                    n_row_addr  = w_next_row;
                    n_cur       = w_next_row;
                    n_rows_left = r_rows_left - WORD_W'(1);
                    if (w_last_row) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_cols_left = r_width;
                        n_phase     = r_flags[0] ? PH_CTRL_LO : PH_RAW;
                    end
                end
            end
        end
    end

    // result of the beat now at the input
    always_comb begin
        w_write = 1'b0;
        w_done  = 1'b0;
        w_pix   = '0;
        w_len   = '0;
        if (!i_record_start) begin
            unique case (r_phase)
                PH_HGT_HI: begin
                    w_done = (r_width == '0) || (w_word == '0);
                end
                PH_RAW: begin
                    w_write = !(i_transparent && (i_record_byte == '0));
                    w_pix   = i_record_byte;
                    w_len   = LEN_W'(1);
                end
                PH_CTRL_HI: begin
                    // opaque fill run, zero-length runs draw nothing
                    w_write = w_fill_bit && !i_transparent && (w_count != '0);
                    w_len   = w_count;
                end
                PH_LIT: begin
                    w_write = 1'b1;
                    w_pix   = i_record_byte;
                    w_len   = LEN_W'(1);
                end
                default: begin
                    w_write = 1'b0;
                end
            endcase
            if (w_row_end && w_last_row) begin
                w_done = 1'b1;
            end
        end
    end

    assign o_flags.valid    = w_write || w_done;
    assign o_flags.write_en = w_write;
    assign o_flags.done     = w_done;
    assign o_address        = w_write ? r_cur : '0;
    assign o_pixel          = w_write ? w_pix : '0;
    assign o_length         = w_write ? w_len : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low          <= n_low;
        r_flags        <= n_flags;
        r_row_origin   <= n_row_origin;
        r_col_origin   <= n_col_origin;
        r_width        <= n_width;
        r_rows_left    <= n_rows_left;
        r_cols_left    <= n_cols_left;
        r_run_left     <= n_run_left;
        r_run_ends_row <= n_run_ends_row;
        r_row_addr     <= n_row_addr;
        r_cur          <= n_cur;
    end

endmodule

// ===== design/rle_sprite_blitter_top.sv =====
`timescale 1ns / 1ps

// run-length sprite blitter: takes one record byte per beat and emits at most one
// framebuffer write per byte, a run of run_length bytes at write_address. a new byte
// is taken every cycle while the output register is empty or being drained, so the
// sustained rate is one beat per cycle; a result appears in the cycle after its byte,
// held in the output register until taken. the parse state advances on every
// accepted byte, and the only multiply (origin row times stride) happens on the
// height byte. the user must write registers only while no sprite is in flight; the block does not check.
module rle_sprite_blitter_top
    import rsb_pkg::*;
#(
    parameter int ROW_STRIDE = DEF_ROW_STRIDE,
    parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [BYTE_W-1:0]     i_record_byte,
    input  logic                  i_record_start,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ADDR_BITS-1:0]  o_write_address,
    output logic [BYTE_W-1:0]     o_pixel_value,
    output logic [LEN_W-1:0]      o_run_length,
    output logic                  o_write_enable,
    output logic                  o_image_done
);

    logic [COORD_W-1:0]   r_base_row;
    logic [COORD_W-1:0]   r_base_col;
    logic                 r_transparent;
    logic                 r_out_valid;
    logic [ADDR_BITS-1:0] r_address;
    logic [BYTE_W-1:0]    r_pixel;
    logic [LEN_W-1:0]     r_length;
    logic                 r_write_en;
    logic                 r_done;

    logic                 w_step;
    t_res_flags           w_flags;
    logic [ADDR_BITS-1:0] w_address;
    logic [BYTE_W-1:0]    w_pixel;
    logic [LEN_W-1:0]     w_length;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_step     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_row    <= '0;
            r_base_col    <= '0;
            r_transparent <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_ROW:    r_base_row    <= i_cfg_data[COORD_W-1:0];
                CFG_BASE_COL:    r_base_col    <= i_cfg_data[COORD_W-1:0];
                CFG_TRANSPARENT: r_transparent <= i_cfg_data[0];
                default: begin
                    r_transparent <= r_transparent;
                end
            endcase
        end
    end

    rsb_parser #(
        .ROW_STRIDE (ROW_STRIDE),
        .ADDR_BITS  (ADDR_BITS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_record_byte  (i_record_byte),
        .i_record_start (i_record_start),
        .i_base_row     (r_base_row),
        .i_base_col     (r_base_col),
        .i_transparent  (r_transparent),
        .o_flags        (w_flags),
        .o_address      (w_address),
        .o_pixel        (w_pixel),
        .o_length       (w_length)
    );

    // output register, refilled in the same cycle it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_flags.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_flags.valid) begin
            r_address  <= w_address;
            r_pixel    <= w_pixel;
            r_length   <= w_length;
            r_write_en <= w_flags.write_en;
            r_done     <= w_flags.done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = r_address;
    assign o_pixel_value   = r_pixel;
    assign o_run_length    = r_length;
    assign o_write_enable  = r_write_en;
    assign o_image_done    = r_done;

endmodule

// ===== design/rsb_checker.sv =====
`timescale 1ns / 1ps
`include "rle_sprite_blitter_top_macros.svh"

module rsb_checker
    import rsb_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [ADDR_BITS-1:0]  o_write_address,
    input logic [BYTE_W-1:0]     o_pixel_value,
    input logic [LEN_W-1:0]      o_run_length,
    input logic                  o_write_enable,
    input logic                  o_image_done
);

    logic w_zero_beat;
    logic w_wr_beat;
    logic w_stall;

    assign w_zero_beat = o_image_done && (o_run_length == '0) && (o_write_address == '0) &&
                         (o_pixel_value == '0);
    assign w_wr_beat   = o_out_valid && o_write_enable;
    assign w_stall     = o_out_valid && !i_out_ready;

    // a beat without a write only exists to end the sprite, and carries zeros
    `RSB_AST_IMP(a_nowrite_is_done, o_out_valid && !o_write_enable, w_zero_beat)

    // every write covers at least one byte
    `RSB_AST_IMP(a_write_len, w_wr_beat, o_run_length != '0)

    // only fills span more than one byte, and fills write zero
    `RSB_AST_IMP(a_pixel_single, w_wr_beat && (o_pixel_value != '0), o_run_length == LEN_W'(1))

    // nothing is presented right after reset
    `RSB_AST_RST(a_reset_empty, !i_rst_n, !o_out_valid)

    // a stalled result holds
    `RSB_AST_NXT(a_out_hold, w_stall, o_out_valid && $stable({o_write_address, o_run_length}))

endmodule

bind rle_sprite_blitter_top rsb_checker #(.ADDR_BITS(ADDR_BITS)) u_rsb_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rsb_pkg::*;

    localparam int ROW_STRIDE = DEF_ROW_STRIDE;
    localparam int ADDR_W     = DEF_ADDR_BITS;

    typedef struct packed {
        logic       start;
        logic [7:0] value;
    } rec_beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        pix;
        logic [11:0]       len;
        logic              we;
        logic              done;
    } blit_write_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_record_byte;
    logic                  i_record_start;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [ADDR_W-1:0]     o_write_address;
    logic [7:0]            o_pixel_value;
    logic [11:0]           o_run_length;
    logic                  o_write_enable;
    logic                  o_image_done;

    rle_sprite_blitter_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_record_byte  (i_record_byte),
        .i_record_start (i_record_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_write_address(o_write_address),
        .o_pixel_value  (o_pixel_value),
        .o_run_length   (o_run_length),
        .o_write_enable (o_write_enable),
        .o_image_done   (o_image_done)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    rec_beat_t   record_fifo[$];
    rec_beat_t   sprite_buf[$];
    blit_write_t expected_writes[$];
    int          err_count = 0;
    int          items_queued = 0;
    bit          in_beat_taken = 1'b0;
    int          in_gap = 0;
    int          out_stall = 0;
    bit          in_idle_on = 1'b0;
    bit          out_idle_on = 1'b0;

    // blitter copy: registers and parse state
    logic [9:0]        base_row_cfg = '0;
    logic [9:0]        base_col_cfg = '0;
    logic              transp_cfg = 1'b0;
    t_phase            phase = PH_IDLE;
    logic [7:0]        lo_hold = '0;
    logic [1:0]        hdr_flags = '0;
    logic [16:0]       row_org = '0;
    logic [16:0]       col_org = '0;
    logic [15:0]       img_width = '0;
    logic [15:0]       rows_rem = '0;
    logic [15:0]       cols_rem = '0;
    logic [11:0]       run_rem = '0;
    logic              run_eol = 1'b0;
    logic [ADDR_W-1:0] row_addr = '0;
    logic [ADDR_W-1:0] cur_addr = '0;

    function automatic void push_write(logic [ADDR_W-1:0] addr, logic [7:0] pix,
                                       logic [11:0] len, logic we, logic done);
        expected_writes.push_back(blit_write_t'{addr, pix, len, we, done});
    endfunction

    // step to the next row, returns 1 when the sprite is finished
    function automatic bit next_row();
        row_addr = row_addr + ADDR_W'(ROW_STRIDE);
        cur_addr = row_addr;
        rows_rem = rows_rem - 16'd1;
        if (rows_rem == 16'd0) begin
            phase = PH_IDLE;
            return 1'b1;
        end
        cols_rem = img_width;
        phase = hdr_flags[0] ? PH_CTRL_LO : PH_RAW;
        return 1'b0;
    endfunction

    function automatic void blit_byte(logic [7:0] b, logic st);
        logic [15:0]       word;
        logic [11:0]       count;
        logic [ADDR_W-1:0] addr;
        logic              fin;
        logic              we;
        word  = {b, lo_hold};
        count = word[11:0];
        addr  = cur_addr;
        fin   = 1'b0;
        if (st) begin
            hdr_flags = b[1:0];
            phase = PH_HDR_HI;
            return;
        end
        case (phase)
            PH_HDR_HI: begin
                row_org = 17'(base_row_cfg);
                col_org = 17'(base_col_cfg);
                phase = hdr_flags[1] ? PH_ROW_LO : PH_WID_LO;
            end
            PH_ROW_LO, PH_COL_LO, PH_WID_LO, PH_HGT_LO, PH_CTRL_LO: begin
                lo_hold = b;
                phase = t_phase'(phase + 4'd1);
            end
            PH_ROW_HI: begin
                row_org = row_org + 17'(word);
                phase = PH_COL_LO;
            end
            PH_COL_HI: begin
                col_org = col_org + 17'(word);
                phase = PH_WID_LO;
            end
            PH_WID_HI: begin
                img_width = word;
                phase = PH_HGT_LO;
            end
            PH_HGT_HI: begin
                rows_rem = word;
                if (img_width == 16'd0 || word == 16'd0) begin
                    phase = PH_IDLE;
                    push_write('0, '0, '0, 1'b0, 1'b1);
                end else begin
                    row_addr = ADDR_W'(32'(row_org) * ROW_STRIDE + 32'(col_org));
                    cur_addr = row_addr;
                    cols_rem = img_width;
                    phase = hdr_flags[0] ? PH_CTRL_LO : PH_RAW;
                end
            end
            PH_RAW: begin
                we = !(transp_cfg && b == 8'd0);
                cur_addr = cur_addr + 1'b1;
                cols_rem = cols_rem - 16'd1;
                if (cols_rem == 16'd0) begin
                    fin = next_row();
                end
                if (we) begin
                    push_write(addr, b, 12'd1, 1'b1, fin);
                end else if (fin) begin
                    push_write('0, '0, '0, 1'b0, 1'b1);
                end
            end
            PH_CTRL_HI: begin
                if (!word[15] && count != 12'd0) begin
                    run_rem = count;
                    run_eol = word[14];
                    phase = PH_LIT;
                end else if (!word[15] || transp_cfg || count == 12'd0) begin
                    // empty literal, skip run or zero-length fill: no write
                    cur_addr = cur_addr + ADDR_W'(word[15] ? count : 12'd0);
                    phase = PH_CTRL_LO;
                    if (word[14]) begin
                        if (next_row()) begin
                            push_write('0, '0, '0, 1'b0, 1'b1);
                        end
                    end
                end else begin
                    cur_addr = cur_addr + ADDR_W'(count);
                    phase = PH_CTRL_LO;
                    if (word[14]) begin
                        fin = next_row();
                    end
                    push_write(addr, 8'd0, count, 1'b1, fin);
                end
            end
            PH_LIT: begin
                cur_addr = cur_addr + 1'b1;
                run_rem = run_rem - 12'd1;
                if (run_rem == 12'd0) begin
                    phase = PH_CTRL_LO;
                    if (run_eol) begin
                        fin = next_row();
                    end
                end
                push_write(addr, b, 12'd1, 1'b1, fin);
            end
            default: begin
                phase = PH_IDLE;
            end
        endcase
    endfunction

    function automatic int pick_gap(bit enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(negedge i_clk) begin : drive_records
        rec_beat_t beat;
        logic      nxt_valid;
        nxt_valid = (i_in_valid === 1'b1);
        if (in_beat_taken) begin
            nxt_valid = 1'b0;
            in_beat_taken = 1'b0;
        end
        if (!nxt_valid && i_rst_n) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (record_fifo.size() != 0) begin
                beat = record_fifo.pop_front();
                i_record_byte <= beat.value;
                i_record_start <= beat.start;
                nxt_valid = 1'b1;
                in_gap = pick_gap(in_idle_on);
            end
        end
        i_in_valid <= nxt_valid;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            out_stall = pick_gap(out_idle_on);
        end
    end

    always @(posedge i_clk) begin : watch_writes
        blit_write_t want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_ROW:    base_row_cfg = i_cfg_data[9:0];
                    CFG_BASE_COL:    base_col_cfg = i_cfg_data[9:0];
                    CFG_TRANSPARENT: transp_cfg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                blit_byte(i_record_byte, i_record_start);
                in_beat_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected beat addr %0h pix %0h len %0d we %0b done %0b",
                             $time, o_write_address, o_pixel_value, o_run_length,
                             o_write_enable, o_image_done);
                    err_count++;
                end else begin
                    want = expected_writes.pop_front();
                    check_field("write_address", want.addr, o_write_address);
                    check_field("pixel_value", want.pix, o_pixel_value);
                    check_field("run_length", want.len, o_run_length);
                    check_field("write_enable", want.we, o_write_enable);
                    check_field("image_done", want.done, o_image_done);
                end
            end
        end
    end

    function automatic void put_byte(logic [7:0] v, logic st);
        sprite_buf.push_back(rec_beat_t'{st, v});
    endfunction

    function automatic void put_word(logic [15:0] w);
        put_byte(w[7:0], 1'b0);
        put_byte(w[15:8], 1'b0);
    endfunction

    // move the staged record to the fifo, optionally cut short
    function automatic void commit_sprite(bit cut_short);
        int n;
        n = sprite_buf.size();
        if (cut_short && n > 1) begin
            n = $urandom_range(1, n - 1);
        end
        for (int i = 0; i < n; i++) begin
            record_fifo.push_back(sprite_buf[i]);
        end
        items_queued += n;
        sprite_buf.delete();
    endfunction

    function automatic logic [7:0] pick_pixel();
        return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
    endfunction

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void gen_sprite(bit may_cut);
        logic        rle;
        logic        offs;
        int unsigned sel;
        int unsigned w;
        int unsigned h;
        int unsigned runs;
        int unsigned cnt;
        logic        fill;
        rle  = 1'($urandom_range(0, 1));
        offs = ($urandom_range(0, 2) == 0);
        put_byte({6'($urandom), offs, rle}, 1'b1);
        put_byte(8'($urandom), 1'b0);
        if (offs) begin
            put_word(pick_offset());
            put_word(pick_offset());
        end
        sel = $urandom_range(0, 19);
        w = (sel == 0) ? 0 : (sel == 2) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        h = (sel == 1) ? 0 : $urandom_range(1, 4);
        if (sel == 0) h = $urandom_range(0, 65535);
        if (sel == 1) w = $urandom_range(0, 65535);
        put_word(16'(w));
        put_word(16'(h));
        if (w != 0 && h != 0) begin
            for (int r = 0; r < h; r++) begin
                if (!rle) begin
                    for (int c = 0; c < w; c++) begin
                        put_byte(pick_pixel(), 1'b0);
                    end
                end else begin
                    runs = $urandom_range(1, 4);
                    for (int k = 0; k < runs; k++) begin
                        fill = ($urandom_range(0, 9) >= 5);
                        if (!fill) begin
                            cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
                        end else begin
                            case ($urandom_range(0, 19))
                                0:       cnt = 0;
                                1:       cnt = 4095;
                                2:       cnt = $urandom_range(31, 4095);
                                default: cnt = $urandom_range(1, 30);
                            endcase
                        end
                        // last run of the row carries the end-of-row flag
                        put_word({fill, k == runs - 1, 2'($urandom), 12'(cnt)});
                        if (!fill) begin
                            for (int p = 0; p < cnt; p++) begin
                                put_byte(pick_pixel(), 1'b0);
                            end
                        end
                    end
                end
            end
        end
        commit_sprite(may_cut && $urandom_range(0, 11) == 0);
        // stray bytes without a start flag
        if ($urandom_range(0, 7) == 0) begin
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
                put_byte(8'($urandom), 1'b0);
            end
            commit_sprite(1'b0);
        end
    endfunction

    task automatic settle();
        while (record_fifo.size() != 0 || i_in_valid || expected_writes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [9:0] row, logic [9:0] col, logic transp);
        write_reg(CFG_BASE_ROW, row);
        write_reg(CFG_BASE_COL, col);
        write_reg(CFG_TRANSPARENT, {9'($urandom), transp});
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_record_byte = '0;
        i_record_start = 1'b0;
        i_out_ready = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // opaque, origin at zero: zero fill, full-count fill with wrap, empty sprite
        set_config(10'd0, 10'd0, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(8'hFF, 1'b0);
        put_word(16'hFFFF);
        put_word(16'hFFFF);
        put_word(16'd1);
        put_word(16'd1);
        put_word(16'h8000);
        put_word(16'hFFFF);
        put_byte(8'h00, 1'b1);
        put_byte(8'h00, 1'b0);
        put_word(16'd0);
        put_word(16'd5);
        commit_sprite(1'b0);
        settle();

        // transparent, origin at max: zero raw pixel ends sprite, skip and literal runs
        set_config(10'd1023, 10'd1023, 1'b1);
        put_byte(8'h00, 1'b1);
        put_byte(8'h00, 1'b0);
        put_word(16'd1);
        put_word(16'd1);
        put_byte(8'h00, 1'b0);
        put_byte(8'h01, 1'b1);
        put_byte(8'h00, 1'b0);
        put_word(16'd3);
        put_word(16'd1);
        put_word(16'h8005);
        put_word(16'h3001);
        put_byte(8'hA5, 1'b0);
        put_word(16'h4000);
        put_byte(8'h12, 1'b0);
        commit_sprite(1'b0);
        settle();

        for (int k = 0; k < 10; k++) begin
            in_idle_on  = (k == 1) || (k > 1 && $urandom_range(0, 3) != 0);
            out_idle_on = (k == 1) || (k > 1 && $urandom_range(0, 3) != 0);
            case (k)
                0:       set_config(10'd1023, 10'd1023, 1'b1);
                1:       set_config(10'd0, 10'd0, 1'b0);
                2:       set_config(10'd1023, 10'd0, 1'b0);
                3:       set_config(10'd0, 10'd1023, 1'b1);
                default: set_config(10'($urandom), 10'($urandom), 1'($urandom));
            endcase
            items_queued = 0;
            while (items_queued < 135) begin
                gen_sprite(1'b1);
            end
            // a whole sprite last, so the phase ends idle
            gen_sprite(1'b0);
            settle();
        end

        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
